[sv/line_feature_signature_distance_assert.svh]
`ifndef LINE_FEATURE_SIGNATURE_DISTANCE_ASSERT_SVH
`define LINE_FEATURE_SIGNATURE_DISTANCE_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define LFSD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfsd assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define LFSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfsd assertion failed");

`endif

[sv/lfsd_pkg.sv]
`default_nettype none

package lfsd_pkg;

  localparam int SIG_W  = 64;
  localparam int DIST_W = 7;
  localparam int LANE_W = 8;
  localparam int LANES  = SIG_W / LANE_W;
  localparam int LANE_CNT_W = 4;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       last_of_line;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [SIG_W-1:0]  line_signature;
  } out_item_t;

  // One finished line signature moving between stages.
  typedef struct packed {
    logic             valid;
    logic [SIG_W-1:0] sig;
  } sig_stage_t;

endpackage

`default_nettype wire

[sv/lfsd_accum.sv]
`default_nettype none

module lfsd_accum
  import lfsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output sig_stage_t      res,
  input  wire logic       res_ready
);

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_A  = 8'h61;
  localparam logic [7:0] CH_C  = 8'h63;
  localparam logic [7:0] CH_D  = 8'h64;
  localparam logic [7:0] CH_E  = 8'h65;
  localparam logic [7:0] CH_G  = 8'h67;
  localparam logic [7:0] CH_H  = 8'h68;
  localparam logic [7:0] CH_I  = 8'h69;
  localparam logic [7:0] CH_N  = 8'h6E;
  localparam logic [7:0] CH_P  = 8'h70;
  localparam logic [7:0] CH_R  = 8'h72;
  localparam logic [7:0] CH_S  = 8'h73;
  localparam logic [7:0] CH_T  = 8'h74;
  localparam logic [7:0] CH_W  = 8'h77;
  localparam logic [7:0] CH_Z  = 8'h7A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [5:0] LETTER_BASE = 6'd10;
  localparam logic [5:0] BIT_WS    = 6'd36;
  localparam logic [5:0] BIT_CTRL  = 6'd37;
  localparam logic [5:0] BIT_PUNCT = 6'd38;
  localparam logic [5:0] BIT_ES    = 6'd39;
  localparam logic [5:0] BIT_CH    = 6'd40;
  localparam logic [5:0] BIT_SH    = 6'd41;
  localparam logic [5:0] BIT_TH    = 6'd42;
  localparam logic [5:0] BIT_PH    = 6'd43;
  localparam logic [5:0] BIT_WH    = 6'd44;
  localparam logic [5:0] BIT_ING   = 6'd60;
  localparam logic [5:0] BIT_AND   = 6'd61;
  localparam logic [5:0] BIT_THE   = 6'd62;
  localparam logic [5:0] BIT_HIGH  = 6'd63;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Features of byte c given nf (0..2) following raw bytes f1, f2.
  function automatic logic [SIG_W-1:0] feat(input logic [7:0] c_raw, input logic [7:0] f1,
                                            input logic [7:0] f2, input logic [1:0] nf);
    logic [7:0]       c;
    logic [SIG_W-1:0] h;
    h = '0;
    c = c_raw;
    if (c >= CH_0 && c <= CH_9) begin
      h[6'(c - CH_0)] = 1'b1;
    end else begin
      if (c >= CH_UA && c <= CH_UZ) c = c ^ 8'h20;
      if (nf >= 2'd2) begin
        if (c == CH_I && f1 == CH_N && f2 == CH_G) h[BIT_ING] = 1'b1;
        if (c == CH_A && f1 == CH_N && f2 == CH_D) h[BIT_AND] = 1'b1;
        if (c == CH_T && f1 == CH_H && f2 == CH_E) h[BIT_THE] = 1'b1;
        if (c == CH_H && f1 == CH_E && f2 == CH_R) h[BIT_THE] = 1'b1;
      end
      if (nf >= 2'd1) begin
        if (c == CH_E && f1 == CH_S) h[BIT_ES] = 1'b1;
        if (c == CH_C && f1 == CH_H) h[BIT_CH] = 1'b1;
        if (c == CH_S && f1 == CH_H) h[BIT_SH] = 1'b1;
        if (c == CH_T && f1 == CH_H) h[BIT_TH] = 1'b1;
        if (c == CH_P && f1 == CH_H) h[BIT_PH] = 1'b1;
        if (c == CH_W && f1 == CH_H) h[BIT_WH] = 1'b1;
      end
      if (c >= CH_A && c <= CH_Z) begin
        h[6'(c - CH_A) + LETTER_BASE] = 1'b1;
      end else begin
        if (is_ws(c)) h[BIT_WS] = 1'b1;
        if (c < CH_SP || c == CH_DEL) h[BIT_CTRL] = 1'b1;
        if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
            (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126))
          h[BIT_PUNCT] = 1'b1;
        if (c > CH_DEL) h[BIT_HIGH] = 1'b1;
      end
    end
    return h;
  endfunction

  logic [SIG_W-1:0] acc_r, acc_nxt;
  logic [7:0]       la0_r, la0_nxt, la1_r, la1_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic             nb_r, nb_nxt;
  sig_stage_t       res_r, res_nxt;
  logic             take;

  assign in_ready = !res_r.valid || res_ready;
  assign take     = in_valid && in_ready;
  assign res      = res_r;

  always_comb begin
    logic [SIG_W-1:0] a;
    logic [7:0]       b;
    b        = in_data.line_byte;
    a        = acc_r;
    la0_nxt  = la0_r;
    la1_nxt  = la1_r;
    pend_nxt = pend_r;
    res_nxt  = res_r;
    if (res_ready) res_nxt.valid = 1'b0;

    // shift the window; classify the oldest byte once two followers exist
    case (pend_r)
      2'd2: begin
        a        = a | feat(la0_r, la1_r, b, 2'd2);
        la0_nxt  = la1_r;
        la1_nxt  = b;
        pend_nxt = 2'd2;
      end
      2'd0: begin
        la0_nxt  = b;
        pend_nxt = 2'd1;
      end
      default: begin
        la1_nxt  = b;
        pend_nxt = 2'd2;
      end
    endcase
    nb_nxt = nb_r || !is_ws(b);

    if (in_data.last_of_line) begin
      // flush the window against the followers left in the line
      if (pend_nxt == 2'd2) begin
        a = a | feat(la0_nxt, la1_nxt, 8'd0, 2'd1) | feat(la1_nxt, 8'd0, 8'd0, 2'd0);
      end else begin
        a = a | feat(la0_nxt, 8'd0, 8'd0, 2'd0);
      end
      if (nb_nxt) begin
        res_nxt.valid = 1'b1;
        res_nxt.sig   = a;
      end
      acc_nxt  = '0;
      la0_nxt  = '0;
      la1_nxt  = '0;
      pend_nxt = '0;
      nb_nxt   = 1'b0;
    end else begin
      acc_nxt = a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      la0_r       <= '0;
      la1_r       <= '0;
      pend_r      <= '0;
      nb_r        <= 1'b0;
      res_r.valid <= 1'b0;
    end else if (take) begin
      acc_r  <= acc_nxt;
      la0_r  <= la0_nxt;
      la1_r  <= la1_nxt;
      pend_r <= pend_nxt;
      nb_r   <= nb_nxt;
      res_r  <= res_nxt;
    end else if (res_ready) begin
      res_r.valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[sv/lfsd_popcnt.sv]
`default_nettype none

module lfsd_popcnt
  import lfsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sig_stage_t       src,
  output logic                  src_ready,
  input  wire logic [SIG_W-1:0] ref_sig,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data
);

  logic                  a_valid_r;
  logic [SIG_W-1:0]      a_sig_r;
  logic [LANE_CNT_W-1:0] a_cnt_r [LANES];
  logic [LANE_CNT_W-1:0] a_cnt_nxt [LANES];
  logic                  a_ready;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  logic [DIST_W-1:0]     dist_nxt;

  assign a_ready   = !out_valid_r || out_ready;
  assign src_ready = !a_valid_r || a_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // per-lane bit counts of the mismatch word
  always_comb begin
    logic [SIG_W-1:0] x;
    x = src.sig ^ ref_sig;
    for (int i = 0; i < LANES; i++) begin
      a_cnt_nxt[i] = '0;
      for (int j = 0; j < LANE_W; j++) begin
        a_cnt_nxt[i] = a_cnt_nxt[i] + LANE_CNT_W'(x[i*LANE_W + j]);
      end
    end
  end

  always_comb begin
    dist_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      dist_nxt = dist_nxt + DIST_W'(a_cnt_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (src_ready) begin
        a_valid_r <= src.valid;
        if (src.valid) begin
          a_sig_r <= src.sig;
          a_cnt_r <= a_cnt_nxt;
        end
      end
      if (a_ready) begin
        out_valid_r <= a_valid_r;
        if (a_valid_r) begin
          out_data_r.distance       <= dist_nxt;
          out_data_r.line_signature <= a_sig_r;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/line_feature_signature_distance.sv]
// The result of a line with a non-blank byte passes through the accumulator
// result register, lane-count register and output register; the window update
// and flush are combinational. Throughput: one byte per cycle while not stalled.
// Reset (rst_n low at a clock edge) clears the line state, the pipeline valids
// and the reference signature to zero.
`default_nettype none
`include "line_feature_signature_distance_assert.svh"

module line_feature_signature_distance
  import lfsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [SIG_W-1:0] cfg_wdata
);

  logic [SIG_W-1:0] ref_r;
  sig_stage_t       acc_res;
  logic             acc_res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else if (cfg_we) begin
      ref_r <= cfg_wdata;
    end
  end

  lfsd_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res       (acc_res),
    .res_ready (acc_res_ready)
  );

  lfsd_popcnt u_popcnt (
    .clk       (clk),
    .rst_n     (rst_n),
    .src       (acc_res),
    .src_ready (acc_res_ready),
    .ref_sig   (ref_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `LFSD_ASSERT_SAME(a_dist_match, out_valid, out_data.distance == DIST_W'($countones(out_data.line_signature ^ ref_r)))
  `LFSD_ASSERT_SAME(a_sig_nonzero, out_valid, out_data.line_signature != '0)
  `LFSD_ASSERT_SAME(a_dist_range, out_valid, out_data.distance <= 7'd64)
  `LFSD_ASSERT_SAME(a_res_from_last, $rose(acc_res.valid), $past(in_valid && in_ready && in_data.last_of_line))

endmodule

`default_nettype wire
